// ===== hdl/tkc_pkg.sv =====
// Shared types, constants and helper functions for the trie keyword counter.
// No dependencies; imported by every module of the block.
package tkc_pkg;

   localparam int NODES    = 4096;
   localparam int NODE_W   = 12;
   localparam int ALPHABET = 26;
   localparam int LETTER_W = 5;
   localparam int KEYWORDS = 32;
   localparam int KW_W     = 5;
   localparam int MARK_W   = 6;
   localparam int CNT_W    = 24;
   localparam int FREE_W   = 13;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic [2:0] OP_DICT = 3'd0;
   localparam logic [2:0] OP_STOP = 3'd1;
   localparam logic [2:0] OP_KEY  = 3'd2;
   localparam logic [2:0] OP_ART  = 3'd3;
   localparam logic [2:0] OP_DOC  = 3'd4;

   // controller to datapath
   typedef struct packed {
      logic              clear;
      logic [NODE_W-1:0] clr_addr;
      logic              accept;
      logic              exec;
      logic              walk;
      logic [KW_W-1:0]   walk_idx;
      logic              walk_last;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic              doc_end;
      logic [MARK_W-1:0] kw_used;
   } sts_type;

   function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
      return (v == CNT_MAX) ? v : v + 1'b1;
   endfunction

   function automatic logic is_letter(input logic [7:0] c);
      return (c >= 8'd97 && c <= 8'd122) || (c >= 8'd65 && c <= 8'd90);
   endfunction

   function automatic logic [LETTER_W-1:0] letter_of(input logic [7:0] c);
      logic [7:0] d;
      d = (c >= 8'd97) ? c - 8'd97 : c - 8'd65;
      return d[LETTER_W-1:0];
   endfunction

endpackage

// ===== hdl/tkc_ctl.sv =====
// Controller state machine: memory clearing sweep, request sequencing and
// the document summary walk. Depends on tkc_pkg.
module tkc_ctl
   import tkc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [1:0] {ST_CLEAR, ST_IDLE, ST_EXEC, ST_WALK} state_type;

   state_type         state_ff;
   logic [NODE_W-1:0] clr_ff;
   logic [KW_W-1:0]   idx_ff;
   logic              walk_last;

   assign walk_last = (sts.kw_used == '0) ||
                      ({1'b0, idx_ff} == sts.kw_used - 1'b1);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         clr_ff   <= '0;
         idx_ff   <= '0;
      end else begin
         unique case (state_ff)
            ST_CLEAR: begin
               clr_ff <= clr_ff + 1'b1;
               if (clr_ff == NODE_W'(NODES - 1)) state_ff <= ST_IDLE;
            end
            ST_IDLE: begin
               if (start) state_ff <= ST_EXEC;
            end
            ST_EXEC: begin
               idx_ff   <= '0;
               state_ff <= sts.doc_end ? ST_WALK : ST_IDLE;
            end
            ST_WALK: begin
               idx_ff <= idx_ff + 1'b1;
               if (walk_last) state_ff <= ST_IDLE;
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign busy          = (state_ff != ST_IDLE);
   assign cmd.clear     = (state_ff == ST_CLEAR);
   assign cmd.clr_addr  = clr_ff;
   assign cmd.accept    = (state_ff == ST_IDLE) && start;
   assign cmd.exec      = (state_ff == ST_EXEC);
   assign cmd.walk      = (state_ff == ST_WALK);
   assign cmd.walk_idx  = idx_ff;
   assign cmd.walk_last = walk_last;

endmodule

// ===== hdl/tkc_dp.sv =====
// Datapath: trie link and word mark memories, walker registers, keyword
// counters and the result register. Depends on tkc_pkg.
module tkc_dp
   import tkc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic [2:0]         req_opcode,
   input  logic [7:0]         req_char_code,
   input  cmd_type            cmd,
   output sts_type            sts,
   output logic               rsp_valid,
   output logic               rsp_kind,
   output logic               rsp_word_counted,
   output logic [5:0]         rsp_keyword_index,
   output logic [CNT_W-1:0]   rsp_keyword_count,
   output logic [CNT_W-1:0]   rsp_doc_frequency,
   output logic [CNT_W-1:0]   rsp_total_words,
   output logic               rsp_trie_full,
   output logic               rsp_last
);

   localparam logic [MARK_W-1:0] KW_LIMIT = MARK_W'(KEYWORDS + 2);

   // one row per node holds all child links of that node
   logic [ALPHABET*NODE_W-1:0] link_mem [NODES];
   logic [MARK_W-1:0]          mark_mem [NODES];

   logic [ALPHABET*NODE_W-1:0] row_ff, row_wdata;
   logic [MARK_W-1:0] mark_ff;
   logic [2:0]        op_ff;
   logic [7:0]        ch_ff;

   logic [NODE_W-1:0] node_ff, node_in;
   logic              in_word_ff, in_word_in;
   logic [FREE_W-1:0] nfree_ff, nfree_in;
   logic [MARK_W-1:0] nkw_ff, nkw_in;
   logic [CNT_W-1:0]  total_ff, total_in;
   logic [CNT_W-1:0]  dkc_ff [KEYWORDS];
   logic [CNT_W-1:0]  dkc_in [KEYWORDS];
   logic [CNT_W-1:0]  kdc_ff [KEYWORDS];
   logic [CNT_W-1:0]  kdc_in [KEYWORDS];

   logic              link_we, mark_we;
   logic [MARK_W-1:0] mark_wdata;

   logic              valid_ff, valid_in, kind_ff, kind_in, cnt_ff, cnt_in;
   logic [5:0]        idx_ff, idx_in;
   logic [CNT_W-1:0]  kc_ff, kc_in, df_ff, df_in, tw_ff, tw_in;
   logic              full_ff, full_in, last_ff, last_in;

   logic                letter_hit, count_hit;
   logic [LETTER_W-1:0] lt;
   logic [NODE_W-1:0]   child;
   logic [MARK_W-1:0]   m_off;
   logic [CNT_W-1:0]    kdc_new;

   assign letter_hit  = is_letter(ch_ff);
   assign lt          = letter_of(ch_ff);
   assign child       = row_ff[lt*NODE_W +: NODE_W];
   assign m_off       = mark_ff - MARK_W'(2);
   assign kdc_new     = (dkc_ff[cmd.walk_idx] != '0) ? sat_inc(kdc_ff[cmd.walk_idx])
                                                     : kdc_ff[cmd.walk_idx];
   assign count_hit   = cmd.exec && in_word_ff &&
                        (op_ff == OP_DOC || (op_ff == OP_ART && !letter_hit));
   assign sts.doc_end = (op_ff == OP_DOC);
   assign sts.kw_used = nkw_ff - MARK_W'(2);

   always_comb begin
      node_in    = node_ff;
      in_word_in = in_word_ff;
      nfree_in   = nfree_ff;
      nkw_in     = nkw_ff;
      total_in   = total_ff;
      dkc_in     = dkc_ff;
      kdc_in     = kdc_ff;
      link_we    = 1'b0;
      row_wdata  = row_ff;
      mark_we    = 1'b0;
      mark_wdata = '0;
      valid_in   = 1'b0;
      kind_in    = 1'b0;
      cnt_in     = 1'b0;
      idx_in     = '0;
      kc_in      = '0;
      df_in      = '0;
      tw_in      = '0;
      full_in    = 1'b0;
      last_in    = 1'b0;

      // count a finished word at an article separator or at document end
      if (count_hit && mark_ff != '0) begin
         total_in = sat_inc(total_ff);
         if (mark_ff >= MARK_W'(2) && m_off < MARK_W'(KEYWORDS))
            dkc_in[m_off[KW_W-1:0]] = sat_inc(dkc_ff[m_off[KW_W-1:0]]);
      end

      if (cmd.exec) begin
         if (op_ff == OP_DOC) begin
            in_word_in = 1'b0;
            node_in    = NODE_W'(1);
         end else if (op_ff <= OP_ART) begin
            if (letter_hit) begin
               in_word_in = 1'b1;
               if (node_ff == '0) begin
                  node_in = '0;
               end else if (child == '0 && op_ff == OP_DICT) begin
                  if (nfree_ff < FREE_W'(NODES)) begin
                     link_we  = 1'b1;
                     row_wdata[lt*NODE_W +: NODE_W] = nfree_ff[NODE_W-1:0];
                     node_in  = nfree_ff[NODE_W-1:0];
                     nfree_in = nfree_ff + 1'b1;
                  end else begin
                     node_in  = '0;
                     valid_in = 1'b1;
                     full_in  = 1'b1;
                  end
               end else begin
                  node_in = child;
               end
            end else if (in_word_ff) begin
               if (op_ff == OP_ART) begin
                  valid_in = 1'b1;
                  cnt_in   = (mark_ff != '0);
                  idx_in   = mark_ff;
               end else if (node_ff != '0) begin
                  if (op_ff == OP_DICT) begin
                     mark_we    = 1'b1;
                     mark_wdata = MARK_W'(1);
                  end else if (op_ff == OP_STOP) begin
                     mark_we    = 1'b1;
                  end else if (mark_ff != '0 && nkw_ff < KW_LIMIT) begin
                     mark_we    = 1'b1;
                     mark_wdata = nkw_ff;
                     nkw_in     = nkw_ff + 1'b1;
                  end
               end
               node_in    = NODE_W'(1);
               in_word_in = 1'b0;
            end
         end
      end

      if (cmd.walk) begin
         valid_in = 1'b1;
         kind_in  = 1'b1;
         tw_in    = total_ff;
         last_in  = cmd.walk_last;
         if (sts.kw_used != '0) begin
            idx_in                 = {1'b0, cmd.walk_idx} + 6'd2;
            kc_in                  = dkc_ff[cmd.walk_idx];
            df_in                  = kdc_new;
            kdc_in[cmd.walk_idx]   = kdc_new;
         end
         if (cmd.walk_last) begin
            total_in = '0;
            for (int i = 0; i < KEYWORDS; i++) dkc_in[i] = '0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.clear) begin
         link_mem[cmd.clr_addr] <= '0;
         mark_mem[cmd.clr_addr] <= '0;
      end else begin
         if (link_we) link_mem[node_ff] <= row_wdata;
         if (mark_we) mark_mem[node_ff] <= mark_wdata;
      end
      if (cmd.accept) begin
         row_ff  <= link_mem[node_ff];
         mark_ff <= mark_mem[node_ff];
         op_ff   <= req_opcode;
         ch_ff   <= req_char_code;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         node_ff    <= NODE_W'(1);
         in_word_ff <= 1'b0;
         nfree_ff   <= FREE_W'(2);
         nkw_ff     <= MARK_W'(2);
         total_ff   <= '0;
         valid_ff   <= 1'b0;
         for (int i = 0; i < KEYWORDS; i++) begin
            dkc_ff[i] <= '0;
            kdc_ff[i] <= '0;
         end
      end else begin
         node_ff    <= node_in;
         in_word_ff <= in_word_in;
         nfree_ff   <= nfree_in;
         nkw_ff     <= nkw_in;
         total_ff   <= total_in;
         valid_ff   <= valid_in;
         dkc_ff     <= dkc_in;
         kdc_ff     <= kdc_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      cnt_ff  <= cnt_in;
      idx_ff  <= idx_in;
      kc_ff   <= kc_in;
      df_ff   <= df_in;
      tw_ff   <= tw_in;
      full_ff <= full_in;
      last_ff <= last_in;
   end

   assign rsp_valid         = valid_ff;
   assign rsp_kind          = kind_ff;
   assign rsp_word_counted  = cnt_ff;
   assign rsp_keyword_index = idx_ff;
   assign rsp_keyword_count = kc_ff;
   assign rsp_doc_frequency = df_ff;
   assign rsp_total_words   = tw_ff;
   assign rsp_trie_full     = full_ff;
   assign rsp_last          = last_ff;

endmodule

// ===== hdl/trie_keyword_counter.sv =====
// Top level of the trie keyword counter: controller plus datapath.
// Depends on tkc_pkg, tkc_ctl and tkc_dp.
//
// Usage:
//  - Request channel: drive req_opcode and req_char_code with start high;
//    the request is taken at a rising edge where busy is low.
//  - Opcodes: dictionary, stopword and keyword characters build and mark
//    the letter trie, article characters are matched, document end closes
//    the current document.
//  - Each character request first reads the trie row and word mark memories
//    at the current node, then updates the walker and writes back a link or
//    mark. busy is high during the update.
//  - A finished article word or a full node store gives one result on the
//    rsp_ ports, shown with rsp_valid for one cycle, in the cycle after the
//    request finished.
//  - Document end starts the summary walk, which emits one entry per cycle,
//    one per assigned keyword (at least one entry), rsp_last marking the
//    final one, then clears the per-document counters.
//  - Reset: after reset is released the block sweeps both trie memories,
//    one node row per cycle, for 4096 cycles with busy high.
//  - The receiver cannot stall; results must be taken as they appear.
module trie_keyword_counter
   import tkc_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             start,
   output logic             busy,
   input  logic [2:0]       req_opcode,
   input  logic [7:0]       req_char_code,
   output logic             rsp_valid,
   output logic             rsp_kind,
   output logic             rsp_word_counted,
   output logic [5:0]       rsp_keyword_index,
   output logic [CNT_W-1:0] rsp_keyword_count,
   output logic [CNT_W-1:0] rsp_doc_frequency,
   output logic [CNT_W-1:0] rsp_total_words,
   output logic             rsp_trie_full,
   output logic             rsp_last
);

   cmd_type cmd;
   sts_type sts;

   // sequence each request and the summary walk
   tkc_ctl u_ctl (
      .clock (clock),
      .reset (reset),
      .start (start),
      .busy  (busy),
      .sts   (sts),
      .cmd   (cmd)
   );

   // hold the trie, counters and result register
   tkc_dp u_dp (
      .clock             (clock),
      .reset             (reset),
      .req_opcode        (req_opcode),
      .req_char_code     (req_char_code),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_valid         (rsp_valid),
      .rsp_kind          (rsp_kind),
      .rsp_word_counted  (rsp_word_counted),
      .rsp_keyword_index (rsp_keyword_index),
      .rsp_keyword_count (rsp_keyword_count),
      .rsp_doc_frequency (rsp_doc_frequency),
      .rsp_total_words   (rsp_total_words),
      .rsp_trie_full     (rsp_trie_full),
      .rsp_last          (rsp_last)
   );

endmodule

// ===== hdl/tkc_checker.sv =====
// Port-level checks for the trie keyword counter, bound to the top level.
// Depends on tkc_pkg and trie_keyword_counter.
module tkc_checker
   import tkc_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             start,
   input logic             busy,
   input logic             rsp_valid,
   input logic             rsp_kind,
   input logic             rsp_word_counted,
   input logic [5:0]       rsp_keyword_index,
   input logic [CNT_W-1:0] rsp_keyword_count,
   input logic [CNT_W-1:0] rsp_doc_frequency,
   input logic [CNT_W-1:0] rsp_total_words,
   input logic             rsp_trie_full,
   input logic             rsp_last
);

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      start && !busy |=> busy) else $error("request taken without busy");

   a_last_summary: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_last |-> rsp_kind) else $error("last on word result");

   a_word_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_kind |-> rsp_keyword_count == '0 &&
      rsp_doc_frequency == '0 && rsp_total_words == '0)
      else $error("word result carries counts");

   a_full_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_trie_full |-> !rsp_kind && !rsp_word_counted &&
      rsp_keyword_index == '0) else $error("full report carries word data");

endmodule

bind trie_keyword_counter tkc_checker u_tkc_checker (.*);
